[sv/pts_pkg.sv]
// shared types and constants for the pinned time-slice thread scheduler
package pts_pkg;

  // time and quantum width
  localparam int T_W = 48;
  localparam logic [T_W-1:0] QUANTUM_RST = 48'd1000000000;

  // request actions
  localparam int ACT_W = 3;
  localparam logic [ACT_W-1:0] ACT_TICK     = 3'd0;
  localparam logic [ACT_W-1:0] ACT_CREATE   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_AFFINITY = 3'd2;
  localparam logic [ACT_W-1:0] ACT_STALL    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_RESUME   = 3'd4;

  // move kinds
  localparam int KIND_W = 2;
  localparam logic [KIND_W-1:0] MV_UNSCHED = 2'd0;
  localparam logic [KIND_W-1:0] MV_SCHED   = 2'd1;
  localparam logic [KIND_W-1:0] MV_ACK     = 2'd2;

  // moves reported per request
  localparam int MAX_MOVES = 16;
  localparam int CNT_W     = 5;

  // source for the core under work
  typedef enum logic [2:0] {
    RC_HOLD,
    RC_ZERO,
    RC_INC,
    RC_EV,
    RC_FREE
  } rc_op_t;

  // controller to datapath commands
  typedef struct packed {
    logic   load;
    logic   decode;
    rc_op_t rc_op;
    logic   tick_dec;
    logic   tick_end;
    logic   zero_q;
    logic   place;
    logic   scan_init;
    logic   scan_step;
    logic   swap_out;
    logic   swap_in;
    logic   flush;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_tick;
    logic is_create;
    logic is_aff;
    logic is_stall;
    logic is_resume;
    logic created;
    logic self_set;
    logic runnable;
    logic ev_valid;
    logic ev_allowed;
    logic free_valid;
    logic tick_hit;
    logic scan_done;
    logic emit_ok;
    logic out_free;
    logic rc_last;
  } dp_status_t;

endpackage

[sv/pts_item_if.sv]
// request channel carrying scheduler events
interface pts_item_if #(
  parameter int SEL_W     = 4,
  parameter int NUM_CORES = 8
);
  import pts_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ACT_W-1:0]     action;
  logic [T_W-1:0]       now_ps;
  logic [SEL_W-1:0]     thread_sel;
  logic [NUM_CORES-1:0] affinity_mask;
  logic                 mask_given;
  logic                 from_self;

  modport source (
    output valid, action, now_ps, thread_sel, affinity_mask, mask_given, from_self,
    input  ready
  );
  modport sink (
    input  valid, action, now_ps, thread_sel, affinity_mask, mask_given, from_self,
    output ready
  );
endinterface

[sv/pts_move_if.sv]
// result channel carrying schedule moves
interface pts_move_if #(
  parameter int TID_W = 5,
  parameter int CID_W = 4
);
  import pts_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] move_kind;
  logic [TID_W-1:0]  moved_thread;
  logic [CID_W-1:0]  target_core;
  logic              last;

  modport source (
    output valid, move_kind, moved_thread, target_core, last,
    input  ready
  );
  modport sink (
    input  valid, move_kind, moved_thread, target_core, last,
    output ready
  );
endinterface

[sv/pts_datapath.sv]
// scheduler state, thread scan, move staging and result register
module pts_datapath #(
  parameter int NUM_CORES   = 8,
  parameter int NUM_THREADS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [pts_pkg::T_W-1:0]                cfg_wdata,
  input  logic [pts_pkg::ACT_W-1:0]              in_action,
  input  logic [pts_pkg::T_W-1:0]                in_now,
  input  logic [((NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1)-1:0] in_sel,
  input  logic [NUM_CORES-1:0]                   in_mask,
  input  logic                                   in_given,
  input  logic                                   in_self,
  input  pts_pkg::dp_cmd_t                       cmd,
  output pts_pkg::dp_status_t                    status,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [pts_pkg::KIND_W-1:0]             out_kind,
  output logic [$clog2(NUM_THREADS+1)-1:0]       out_thread,
  output logic [$clog2(NUM_CORES+1)-1:0]         out_core,
  output logic                                   out_last
);
  import pts_pkg::*;

  localparam int TW    = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
  localparam int CW    = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
  localparam int TID_W = $clog2(NUM_THREADS + 1);
  localparam int CID_W = $clog2(NUM_CORES + 1);
  localparam logic [TID_W-1:0] THREAD_NONE = TID_W'(NUM_THREADS);
  localparam logic [CID_W-1:0] CORE_NONE   = CID_W'(NUM_CORES);
  localparam logic [NUM_CORES-1:0] ALL_CORES = '1;

  // configuration and captured request
  logic [T_W-1:0]       quantum;
  logic [ACT_W-1:0]     act;
  logic [T_W-1:0]       now;
  logic [TW-1:0]        sel;
  logic [NUM_CORES-1:0] mask;
  logic                 given;
  logic                 self_set;

  // thread and core tables
  logic [NUM_CORES-1:0] thr_aff  [NUM_THREADS];
  logic [NUM_THREADS-1:0] thr_run;
  logic [NUM_THREADS-1:0] thr_made;
  logic [CID_W-1:0]     thr_core [NUM_THREADS];
  logic [T_W-1:0]       thr_in   [NUM_THREADS];
  logic [T_W-1:0]       thr_out  [NUM_THREADS];
  logic [TID_W-1:0]     core_thr [NUM_CORES];
  logic [T_W-1:0]       core_q   [NUM_CORES];
  logic [T_W-1:0]       last_tick;
  logic [T_W-1:0]       delta;

  // work registers
  logic [CID_W-1:0]     ev_core;
  logic [CW-1:0]        rc;
  logic [TW-1:0]        scan_t;
  logic [TID_W-1:0]     best;
  logic signed [T_W:0]  best_score;
  logic                 best_v;

  // staged move
  logic                 pend_v;
  logic [KIND_W-1:0]    pend_kind;
  logic [TID_W-1:0]     pend_thr;
  logic [CID_W-1:0]     pend_core;
  logic [CNT_W-1:0]     emit_cnt;

  // combinational views
  logic [TW-1:0]        rd_t;
  logic [NUM_CORES-1:0] aff_rd;
  logic                 run_rd;
  logic                 made_rd;
  logic [CID_W-1:0]     core_rd;
  logic [T_W-1:0]       in_rd;
  logic [T_W-1:0]       out_rd;
  logic [CID_W-1:0]     rc_ext;
  logic signed [T_W:0]  score;
  logic                 elig;
  logic                 sel_ok;
  logic [CW-1:0]        ev_idx;
  logic                 ev_valid;
  logic                 free_v;
  logic [CW-1:0]        free_c;
  logic [TID_W-1:0]     cur;
  logic                 cur_v;
  logic                 best_valid;
  logic                 differ;
  logic [T_W:0]         out_sum;
  logic [T_W-1:0]       out_time;
  logic                 out_free;
  logic                 emit_ok;
  logic                 em_req;
  logic [KIND_W-1:0]    em_kind;
  logic [TID_W-1:0]     em_thr;
  logic [CID_W-1:0]     em_core;

  // one read port into the thread table
  assign rd_t    = cmd.scan_step ? scan_t : sel;
  assign aff_rd  = thr_aff[rd_t];
  assign run_rd  = thr_run[rd_t];
  assign made_rd = thr_made[rd_t];
  assign core_rd = thr_core[rd_t];
  assign in_rd   = thr_in[rd_t];
  assign out_rd  = thr_out[rd_t];

  assign rc_ext = CID_W'(rc);
  assign sel_ok = {1'b0, sel} < (TW+1)'(NUM_THREADS);

  // scan score and eligibility for the core under work
  always_comb begin
    if (core_rd == CORE_NONE) begin
      score = $signed({1'b0, now}) - $signed({1'b0, out_rd});
    end else begin
      score = $signed({1'b0, in_rd}) - $signed({1'b0, now});
    end
  end
  assign elig = aff_rd[rc] && run_rd && (core_rd == CORE_NONE || core_rd == rc_ext);

  // event core of the selected thread
  assign ev_idx   = ev_core[CW-1:0];
  assign ev_valid = ev_core != CORE_NONE;

  // lowest free core allowed for the selected thread
  always_comb begin
    free_v = 1'b0;
    free_c = '0;
    for (int c = NUM_CORES - 1; c >= 0; c--) begin
      if (aff_rd[c] && core_thr[c] == THREAD_NONE) begin
        free_v = 1'b1;
        free_c = CW'(c);
      end
    end
  end

  // swap decisions
  assign cur        = core_thr[rc];
  assign cur_v      = cur != THREAD_NONE;
  assign best_valid = best != THREAD_NONE;
  assign differ     = cur != best;
  assign out_sum    = {1'b0, now} + (T_W+1)'(rc);
  assign out_time   = out_sum[T_W] ? '1 : out_sum[T_W-1:0];

  // move selection
  always_comb begin
    em_req  = 1'b0;
    em_kind = MV_ACK;
    em_thr  = THREAD_NONE;
    em_core = CORE_NONE;
    if (cmd.place && free_v) begin
      em_req  = 1'b1;
      em_kind = MV_SCHED;
      em_thr  = TID_W'(sel);
      em_core = CID_W'(free_c);
    end else if (cmd.swap_out && differ && cur_v) begin
      em_req  = 1'b1;
      em_kind = MV_UNSCHED;
      em_thr  = cur;
      em_core = CORE_NONE;
    end else if (cmd.swap_in && differ && best_valid) begin
      em_req  = 1'b1;
      em_kind = MV_SCHED;
      em_thr  = best;
      em_core = rc_ext;
    end
  end

  assign out_free = !out_valid || out_ready;
  assign emit_ok  = !pend_v || out_free;

  // status to the controller
  always_comb begin
    status.is_tick    = act == ACT_TICK;
    status.is_create  = act == ACT_CREATE && sel_ok;
    status.is_aff     = act == ACT_AFFINITY && sel_ok;
    status.is_stall   = act == ACT_STALL && sel_ok;
    status.is_resume  = act == ACT_RESUME && sel_ok;
    status.created    = made_rd;
    status.self_set   = self_set;
    status.runnable   = run_rd;
    status.ev_valid   = ev_valid;
    status.ev_allowed = ev_valid && aff_rd[ev_idx];
    status.free_valid = free_v;
    status.tick_hit   = (delta > core_q[rc]) || (core_thr[rc] == THREAD_NONE);
    status.scan_done  = scan_t == TW'(NUM_THREADS - 1);
    status.emit_ok    = emit_ok;
    status.out_free   = out_free;
    status.rc_last    = rc == CW'(NUM_CORES - 1);
  end

  // quantum register
  always_ff @(posedge clk) begin
    if (rst) begin
      quantum <= QUANTUM_RST;
    end else if (cfg_we) begin
      quantum <= cfg_wdata;
    end
  end

  // request capture, elapsed time and event core
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act      <= in_action;
      now      <= in_now;
      sel      <= in_sel;
      mask     <= in_mask;
      given    <= in_given;
      self_set <= in_self;
    end
    if (cmd.decode) begin
      ev_core <= core_rd;
      delta   <= (now >= last_tick) ? now - last_tick : '0;
    end
  end

  // last tick time
  always_ff @(posedge clk) begin
    if (rst) begin
      last_tick <= '0;
    end else if (cmd.tick_end) begin
      last_tick <= now;
    end
  end

  // thread table updates
  always_ff @(posedge clk) begin
    if (rst) begin
      thr_run  <= '0;
      thr_made <= '0;
      for (int t = 0; t < NUM_THREADS; t++) begin
        thr_aff[t]  <= '0;
        thr_core[t] <= CORE_NONE;
        thr_in[t]   <= '0;
        thr_out[t]  <= '0;
      end
    end else begin
      if (cmd.decode) begin
        if (status.is_create && !made_rd) begin
          thr_made[sel] <= 1'b1;
          thr_run[sel]  <= 1'b1;
          if (given) begin
            thr_aff[sel] <= mask;
          end else if (aff_rd == '0) begin
            thr_aff[sel] <= ALL_CORES;
          end
        end
        if (status.is_aff) begin
          thr_aff[sel] <= given ? mask : ALL_CORES;
        end
        if (status.is_stall && made_rd) begin
          thr_run[sel] <= 1'b0;
        end
        if (status.is_resume && made_rd) begin
          thr_run[sel] <= 1'b1;
        end
      end
      if (cmd.place) begin
        thr_core[sel] <= free_v ? CID_W'(free_c) : CORE_NONE;
      end
      if (cmd.swap_out && differ && cur_v) begin
        thr_core[cur[TW-1:0]] <= CORE_NONE;
        thr_out[cur[TW-1:0]]  <= out_time;
      end
      if (cmd.swap_in && differ && best_valid) begin
        thr_core[best[TW-1:0]] <= rc_ext;
        thr_in[best[TW-1:0]]   <= now;
      end
    end
  end

  // core table updates
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CORES; c++) begin
        core_thr[c] <= THREAD_NONE;
        core_q[c]   <= '0;
      end
    end else begin
      if (cmd.place && free_v) begin
        core_thr[free_c] <= TID_W'(sel);
        core_q[free_c]   <= quantum;
      end
      if (cmd.swap_in) begin
        if (differ) begin
          core_thr[rc] <= best;
        end
        core_q[rc] <= quantum;
      end
      if (cmd.tick_dec) begin
        core_q[rc] <= core_q[rc] - delta;
      end
      if (cmd.zero_q) begin
        core_q[ev_idx] <= '0;
      end
    end
  end

  // core under work
  always_ff @(posedge clk) begin
    case (cmd.rc_op)
      RC_HOLD: rc <= rc;
      RC_ZERO: rc <= '0;
      RC_INC:  rc <= rc + CW'(1);
      RC_EV:   rc <= ev_idx;
      RC_FREE: rc <= free_c;
      default: rc <= rc;
    endcase
  end

  // thread scan, one thread a cycle
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      scan_t <= '0;
      best   <= THREAD_NONE;
      best_v <= 1'b0;
    end else if (cmd.scan_step) begin
      scan_t <= scan_t + TW'(1);
      if (elig && (!best_v || score > best_score)) begin
        best       <= TID_W'(scan_t);
        best_score <= score;
        best_v     <= 1'b1;
      end
    end
  end

  // move staging and result register; the staged move becomes last on flush
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend_v    <= 1'b0;
      emit_cnt  <= '0;
    end else begin
      if (cmd.flush) begin
        out_valid  <= 1'b1;
        out_kind   <= pend_v ? pend_kind : MV_ACK;
        out_thread <= pend_v ? pend_thr : THREAD_NONE;
        out_core   <= pend_v ? pend_core : CORE_NONE;
        out_last   <= 1'b1;
        pend_v     <= 1'b0;
        emit_cnt   <= '0;
      end else if (em_req && emit_cnt < CNT_W'(MAX_MOVES)) begin
        if (pend_v) begin
          out_valid  <= 1'b1;
          out_kind   <= pend_kind;
          out_thread <= pend_thr;
          out_core   <= pend_core;
          out_last   <= 1'b0;
        end else if (out_valid && out_ready) begin
          out_valid <= 1'b0;
        end
        pend_v    <= 1'b1;
        pend_kind <= em_kind;
        pend_thr  <= em_thr;
        pend_core <= em_core;
        emit_cnt  <= emit_cnt + CNT_W'(1);
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[sv/pts_ctrl.sv]
// sequencing state machine for the scheduler
module pts_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pts_pkg::dp_status_t status,
  output pts_pkg::dp_cmd_t    cmd
);
  import pts_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE       = 15'b000000000000001,
    S_DECODE     = 15'b000000000000010,
    S_PLACE      = 15'b000000000000100,
    S_AFF_CHK    = 15'b000000000001000,
    S_STALL_GO   = 15'b000000000010000,
    S_RES_GO     = 15'b000000000100000,
    S_TICK_CORE  = 15'b000000001000000,
    S_TICK_NEXT  = 15'b000000010000000,
    S_RS_INIT    = 15'b000000100000000,
    S_SCAN       = 15'b000001000000000,
    S_SWAP_OUT   = 15'b000010000000000,
    S_SWAP_IN    = 15'b000100000000000,
    S_AFTER_SELF = 15'b001000000000000,
    S_FLUSH      = 15'b010000000000000,
    S_SPARE      = 15'b100000000000000
  } state_t;

  typedef enum logic [1:0] {
    RET_TICK,
    RET_SELF,
    RET_DONE
  } ret_t;

  state_t state, state_next;
  ret_t   ret, ret_next;

  // state and return point registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= RET_DONE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  assign in_ready = state == S_IDLE;

  // next state and commands
  always_comb begin
    state_next = state;
    ret_next   = ret;
    cmd        = '0;
    cmd.rc_op  = RC_HOLD;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        if (status.is_tick) begin
          cmd.rc_op  = RC_ZERO;
          state_next = S_TICK_CORE;
        end else if (status.is_create && !status.created) begin
          state_next = S_PLACE;
        end else if (status.is_aff && status.created) begin
          state_next = S_AFF_CHK;
        end else if (status.is_stall && status.created) begin
          state_next = S_STALL_GO;
        end else if (status.is_resume && status.created) begin
          state_next = S_RES_GO;
        end else begin
          state_next = S_FLUSH;
        end
      end
      S_PLACE: begin
        if (status.emit_ok) begin
          cmd.place  = 1'b1;
          state_next = S_FLUSH;
        end
      end
      S_AFF_CHK: begin
        if (status.self_set) begin
          if (status.ev_valid) begin
            cmd.rc_op  = RC_EV;
            ret_next   = RET_SELF;
            state_next = S_RS_INIT;
          end else begin
            state_next = S_FLUSH;
          end
        end else if (status.ev_valid && !status.ev_allowed) begin
          cmd.zero_q = 1'b1;
          state_next = S_FLUSH;
        end else if (status.runnable && !status.ev_valid) begin
          state_next = S_RES_GO;
        end else begin
          state_next = S_FLUSH;
        end
      end
      S_STALL_GO: begin
        if (status.ev_valid) begin
          cmd.rc_op  = RC_EV;
          ret_next   = RET_DONE;
          state_next = S_RS_INIT;
        end else begin
          state_next = S_FLUSH;
        end
      end
      S_RES_GO: begin
        if (status.free_valid) begin
          cmd.rc_op  = RC_FREE;
          ret_next   = RET_DONE;
          state_next = S_RS_INIT;
        end else begin
          state_next = S_FLUSH;
        end
      end
      S_TICK_CORE: begin
        if (status.tick_hit) begin
          ret_next   = RET_TICK;
          state_next = S_RS_INIT;
        end else begin
          cmd.tick_dec = 1'b1;
          state_next   = S_TICK_NEXT;
        end
      end
      S_TICK_NEXT: begin
        if (status.rc_last) begin
          cmd.tick_end = 1'b1;
          state_next   = S_FLUSH;
        end else begin
          cmd.rc_op  = RC_INC;
          state_next = S_TICK_CORE;
        end
      end
      S_RS_INIT: begin
        cmd.scan_init = 1'b1;
        state_next    = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_done) begin
          state_next = S_SWAP_OUT;
        end
      end
      S_SWAP_OUT: begin
        if (status.emit_ok) begin
          cmd.swap_out = 1'b1;
          state_next   = S_SWAP_IN;
        end
      end
      S_SWAP_IN: begin
        if (status.emit_ok) begin
          cmd.swap_in = 1'b1;
          case (ret)
            RET_TICK: state_next = S_TICK_NEXT;
            RET_SELF: state_next = S_AFTER_SELF;
            RET_DONE: state_next = S_FLUSH;
            default:  state_next = S_FLUSH;
          endcase
        end
      end
      S_AFTER_SELF: begin
        state_next = status.ev_allowed ? S_FLUSH : S_RES_GO;
      end
      S_FLUSH: begin
        if (status.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[sv/pinned_time_slice_thread_scheduler_top.sv]
// top level of the pinned time-slice thread scheduler
// Takes one request at a time and answers it with its schedule moves, the final one marked last
// (an acknowledge when nothing moved). Every core reschedule walks the whole thread table one
// thread a cycle; a stall or resume does one reschedule, a self affinity change up to two, and a
// tick up to NUM_CORES of them. Moves leave through a staging register and an output register,
// so a slow consumer adds stall cycles but never blocks the first move.
module pinned_time_slice_thread_scheduler_top #(
  parameter int NUM_CORES   = 8,
  parameter int NUM_THREADS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [pts_pkg::T_W-1:0] cfg_wdata,
  pts_item_if.sink                items,
  pts_move_if.source              moves
);
  import pts_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencing
  pts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_ready (items.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // tables, scan and result register
  pts_datapath #(
    .NUM_CORES   (NUM_CORES),
    .NUM_THREADS (NUM_THREADS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_action  (items.action),
    .in_now     (items.now_ps),
    .in_sel     (items.thread_sel),
    .in_mask    (items.affinity_mask),
    .in_given   (items.mask_given),
    .in_self    (items.from_self),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (moves.valid),
    .out_ready  (moves.ready),
    .out_kind   (moves.move_kind),
    .out_thread (moves.moved_thread),
    .out_core   (moves.target_core),
    .out_last   (moves.last)
  );

`ifndef SYNTH
  // a request is worked on alone
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    (items.valid && items.ready) |=> !items.ready)
    else $error("request accepted while another is in work");

  // the closing result only goes out when the output register has room
  a_flush_room: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |-> status.out_free)
    else $error("closing result would overwrite a waiting result");

  // moves are only staged when the stage can drain
  a_move_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.place || cmd.swap_out || cmd.swap_in) |-> status.emit_ok)
    else $error("move staged with no room");
`endif

endmodule

[test/pinned_time_slice_thread_scheduler_top_tb.sv]
// self-checking testbench for the pinned time-slice thread scheduler
module pinned_time_slice_thread_scheduler_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pts_pkg::*;

  localparam int NCORE = 8;
  localparam int NTHR = 16;
  localparam logic [3:0] NO_CORE = 4'd8;
  localparam logic [4:0] NO_THREAD = 5'd16;
  localparam logic [T_W-1:0] T_MAX = {T_W{1'b1}};
  localparam int DRAIN_CYCLES = 220;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int RANDOM_REQS = 210;

  typedef struct {
    logic [ACT_W-1:0] action;
    logic [T_W-1:0]   now_ps;
    logic [3:0]       thread_sel;
    logic [7:0]       affinity_mask;
    logic             mask_given;
    logic             from_self;
  } sched_req_t;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [4:0]        thr;
    logic [3:0]        core;
    logic              last;
  } move_t;

  // scheduler state mirror and queue of expected moves
  class sched_scoreboard;
    logic [T_W-1:0] quantum;
    logic [7:0]     aff[NTHR];
    bit             runnable[NTHR];
    bit             created[NTHR];
    logic [3:0]     tcore[NTHR];
    logic [T_W-1:0] last_in[NTHR];
    logic [T_W-1:0] last_out[NTHR];
    logic [4:0]     cthr[NCORE];
    logic [T_W-1:0] qleft[NCORE];
    logic [T_W-1:0] last_tick;
    move_t          batch[$];
    move_t          expected_moves[$];
    int             errors;

    function new();
      quantum = QUANTUM_RST;
      for (int i = 0; i < NTHR; i++) begin
        aff[i] = '0;
        runnable[i] = 0;
        created[i] = 0;
        tcore[i] = NO_CORE;
        last_in[i] = '0;
        last_out[i] = '0;
      end
      for (int c = 0; c < NCORE; c++) begin
        cthr[c] = NO_THREAD;
        qleft[c] = '0;
      end
      last_tick = '0;
      errors = 0;
    endfunction

    function void add_move(logic [KIND_W-1:0] k, logic [4:0] t, logic [3:0] c);
      move_t m;
      if (batch.size() < MAX_MOVES) begin
        m.kind = k;
        m.thr = t;
        m.core = c;
        m.last = 1'b0;
        batch.push_back(m);
      end
    endfunction

    function logic [3:0] free_core(int t);
      for (int c = 0; c < NCORE; c++)
        if (aff[t][c] && cthr[c] == NO_THREAD) return c[3:0];
      return NO_CORE;
    endfunction

    // pick the longest-waiting eligible thread for core c
    function void resched(logic [T_W-1:0] now, int c);
      logic [4:0] cur;
      logic [4:0] best;
      longint best_sc;
      longint sc;
      logic [T_W:0] out_t;
      logic [3:0] old;
      cur = cthr[c];
      best = NO_THREAD;
      best_sc = 64'sh8000_0000_0000_0000;
      for (int t = 0; t < NTHR; t++) begin
        if (!aff[t][c] || !runnable[t]) continue;
        if (tcore[t] != NO_CORE && tcore[t] != c) continue;
        if (tcore[t] != NO_CORE)
          sc = longint'({16'b0, last_in[t]}) - longint'({16'b0, now});
        else
          sc = longint'({16'b0, now}) - longint'({16'b0, last_out[t]});
        if (sc > best_sc) begin
          best = t[4:0];
          best_sc = sc;
        end
      end
      if (cur != best) begin
        if (cur < NTHR) begin
          out_t = {1'b0, now} + (T_W+1)'(c);
          tcore[cur] = NO_CORE;
          last_out[cur] = out_t[T_W] ? T_MAX : out_t[T_W-1:0];
          add_move(MV_UNSCHED, cur, NO_CORE);
        end
        cthr[c] = best;
        if (best < NTHR) begin
          old = tcore[best];
          if (old < NCORE && old != c) cthr[old] = NO_THREAD;
          tcore[best] = c[3:0];
          last_in[best] = now;
          add_move(MV_SCHED, best, c[3:0]);
        end
      end
      qleft[c] = quantum;
    endfunction

    // work out the moves an accepted request causes
    function void note_request(sched_req_t r);
      logic [T_W-1:0] delta;
      logic [7:0] m;
      int t;
      logic [3:0] c;
      logic [3:0] f;
      batch.delete();
      t = r.thread_sel;
      m = r.affinity_mask;
      if (r.action == ACT_TICK) begin
        delta = (r.now_ps >= last_tick) ? r.now_ps - last_tick : '0;
        for (int k = 0; k < NCORE; k++) begin
          if (delta > qleft[k] || cthr[k] == NO_THREAD) resched(r.now_ps, k);
          else qleft[k] = qleft[k] - delta;
        end
        last_tick = r.now_ps;
      end else if (r.action == ACT_CREATE) begin
        if (!created[t]) begin
          created[t] = 1;
          runnable[t] = 1;
          if (r.mask_given) aff[t] = m;
          else if (aff[t] == 0) aff[t] = 8'hFF;
          f = free_core(t);
          tcore[t] = f;
          if (f < NCORE) begin
            cthr[f] = t[4:0];
            qleft[f] = quantum;
            add_move(MV_SCHED, t[4:0], f);
          end
        end
      end else if (r.action == ACT_AFFINITY) begin
        aff[t] = r.mask_given ? m : 8'hFF;
        if (created[t]) begin
          c = tcore[t];
          if (r.from_self) begin
            if (c < NCORE) begin
              qleft[c] = '0;
              resched(r.now_ps, c);
              if (!aff[t][c]) begin
                f = free_core(t);
                if (f < NCORE) resched(r.now_ps, f);
              end
            end
          end else if (c < NCORE && !aff[t][c]) begin
            qleft[c] = '0;
          end else if (runnable[t] && c == NO_CORE) begin
            f = free_core(t);
            if (f < NCORE) resched(r.now_ps, f);
          end
        end
      end else if ((r.action == ACT_STALL || r.action == ACT_RESUME) && created[t]) begin
        if (r.action == ACT_STALL) begin
          runnable[t] = 0;
          c = tcore[t];
          if (c < NCORE) resched(r.now_ps, c);
        end else begin
          runnable[t] = 1;
          f = free_core(t);
          if (f < NCORE) resched(r.now_ps, f);
        end
      end
      if (batch.size() == 0) add_move(MV_ACK, NO_THREAD, NO_CORE);
      batch[batch.size()-1].last = 1'b1;
      foreach (batch[i]) expected_moves.push_back(batch[i]);
    endfunction

    function void check_move(move_t got);
      move_t want;
      if (expected_moves.size() == 0) begin
        $error("move with nothing expected: kind %0d thread %0d core %0d",
               got.kind, got.thr, got.core);
        errors++;
        return;
      end
      want = expected_moves.pop_front();
      if (got.kind !== want.kind) begin
        $error("move_kind: expected %0d, got %0d", want.kind, got.kind);
        errors++;
      end
      if (got.thr !== want.thr) begin
        $error("moved_thread: expected %0d, got %0d", want.thr, got.thr);
        errors++;
      end
      if (got.core !== want.core) begin
        $error("target_core: expected %0d, got %0d", want.core, got.core);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [T_W-1:0] cfg_wdata;

  pts_item_if #(.SEL_W(4), .NUM_CORES(NCORE)) items_ch ();
  pts_move_if #(.TID_W(5), .CID_W(4)) moves_ch ();

  pinned_time_slice_thread_scheduler_top #(
    .NUM_CORES(NCORE),
    .NUM_THREADS(NTHR)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .items(items_ch),
    .moves(moves_ch)
  );

  sched_scoreboard sb;
  logic [T_W-1:0] cur_now;
  bit stim_done;
  int idle_cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // random gap length: mostly short, a few long
  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  task automatic send_req(sched_req_t r);
    items_ch.action = r.action;
    items_ch.now_ps = r.now_ps;
    items_ch.thread_sel = r.thread_sel;
    items_ch.affinity_mask = r.affinity_mask;
    items_ch.mask_given = r.mask_given;
    items_ch.from_self = r.from_self;
    items_ch.valid = 1'b1;
    do @(posedge clk); while (!items_ch.ready);
    sb.note_request(r);
    @(negedge clk);
    items_ch.valid = 1'b0;
    repeat (gap_len()) @(negedge clk);
  endtask

  task automatic req(logic [ACT_W-1:0] act, logic [3:0] t, logic [7:0] m, bit given, bit slf);
    sched_req_t r;
    r.action = act;
    r.now_ps = cur_now;
    r.thread_sel = t;
    r.affinity_mask = m;
    r.mask_given = given;
    r.from_self = slf;
    send_req(r);
  endtask

  // wait for all moves, let the block settle, then write the quantum
  task automatic set_quantum(logic [T_W-1:0] q);
    while (sb.expected_moves.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_wdata = q;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.quantum = q;
  endtask

  task automatic advance_time(logic [T_W-1:0] q);
    logic [T_W:0] sum;
    logic [T_W-1:0] step;
    case ($urandom_range(0, 7))
      0: step = '0;
      1, 2, 3: step = T_W'($urandom_range(1, 50));
      4, 5: step = (q > 48'd100000) ? T_W'($urandom_range(50000, 120000))
                                    : q + T_W'($urandom_range(0, 2));
      6: step = T_W'($urandom_range(0, 5000));
      default: step = T_W'($urandom_range(1000000, 1200000000));
    endcase
    sum = {1'b0, cur_now} + step;
    cur_now = sum[T_W] ? T_MAX : sum[T_W-1:0];
  endtask

  task automatic random_req(logic [T_W-1:0] q);
    int r;
    logic [ACT_W-1:0] act;
    advance_time(q);
    r = $urandom_range(0, 99);
    if (r < 35) act = ACT_TICK;
    else if (r < 50) act = ACT_CREATE;
    else if (r < 68) act = ACT_AFFINITY;
    else if (r < 81) act = ACT_STALL;
    else if (r < 95) act = ACT_RESUME;
    else act = ACT_W'($urandom_range(ACT_RESUME + 1, 7));
    req(act, 4'($urandom_range(0, NTHR - 1)), 8'($urandom_range(0, 255)),
        $urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)));
  endtask

  // result side: check accepted moves, stall at random
  initial begin
    move_t got;
    int stall;
    moves_ch.ready = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && moves_ch.valid && moves_ch.ready) begin
        got.kind = moves_ch.move_kind;
        got.thr = moves_ch.moved_thread;
        got.core = moves_ch.target_core;
        got.last = moves_ch.last;
        sb.check_move(got);
      end
      @(negedge clk);
      if (stall > 0) begin
        stall--;
        moves_ch.ready = 1'b0;
      end else begin
        stall = gap_len();
        moves_ch.ready = (stall == 0);
      end
    end
  end

  // watchdog on cycles without any accepted request or move
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((items_ch.valid && items_ch.ready) || (moves_ch.valid && moves_ch.ready))
        idle_cycles = 0;
      else if (!rst)
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    logic [T_W-1:0] quanta[4];
    sb = new();
    stim_done = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    items_ch.valid = 1'b0;
    items_ch.action = ACT_TICK;
    items_ch.now_ps = '0;
    items_ch.thread_sel = '0;
    items_ch.affinity_mask = '0;
    items_ch.mask_given = 1'b0;
    items_ch.from_self = 1'b0;
    cur_now = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part at the reset quantum
    req(ACT_TICK, 4'd0, 8'h00, 0, 0);
    req(ACT_CREATE, 4'd0, 8'h00, 0, 0);
    req(ACT_CREATE, 4'd1, 8'h01, 1, 0);
    req(ACT_CREATE, 4'd2, 8'h00, 1, 0);
    req(ACT_CREATE, 4'd1, 8'hFF, 1, 0);
    req(ACT_STALL, 4'd9, 8'h00, 0, 0);
    req(ACT_RESUME, 4'd9, 8'h00, 0, 0);
    req(ACT_AFFINITY, 4'd9, 8'h30, 1, 0);
    req(ACT_CREATE, 4'd9, 8'h00, 0, 0);
    cur_now = 48'd100;
    req(ACT_AFFINITY, 4'd1, 8'h80, 1, 1);
    req(ACT_AFFINITY, 4'd0, 8'h02, 1, 0);
    req(ACT_AFFINITY, 4'd2, 8'h00, 0, 0);
    req(ACT_STALL, 4'd0, 8'h00, 0, 0);
    req(ACT_RESUME, 4'd0, 8'h00, 0, 0);
    req(ACT_W'(ACT_RESUME + 1), 4'd3, 8'hFF, 1, 1);
    req(3'd7, 4'd15, 8'hFF, 1, 1);
    for (int t = 3; t < 16; t += 2) req(ACT_CREATE, t[3:0], 8'hFF, 1, 0);
    cur_now = 48'd2000000000;
    req(ACT_TICK, 4'd0, 8'h00, 0, 0);
    cur_now = 48'd5;
    req(ACT_TICK, 4'd0, 8'h00, 0, 0);
    cur_now = 48'd2000000000;

    // random phases across several slice lengths
    quanta[0] = 48'd1;
    quanta[1] = T_W'($urandom_range(1000, 100000));
    quanta[2] = T_MAX;
    quanta[3] = 48'd500;
    for (int i = 0; i < RANDOM_REQS / 5; i++) random_req(QUANTUM_RST);
    for (int p = 0; p < 4; p++) begin
      set_quantum(quanta[p]);
      if (p == 3) cur_now = T_MAX - 48'd3000;
      for (int i = 0; i < RANDOM_REQS / 5; i++) random_req(quanta[p]);
    end

    // drain
    while (sb.expected_moves.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.expected_moves.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
